### rtl/rbch_pkg.sv
// ----------------------------------------------------------------------------
// rbch_pkg: shared types and constants for the ray/box closest-hit block
// Holds field widths, register indexes and the structs that pass between
// the front end, the back end and the slab divider.
// ----------------------------------------------------------------------------
package rbch_pkg;

    // Field widths.
    localparam int unsigned CW      = 32;  // coordinate, owner and register width
    localparam int unsigned DIST_W  = 31;  // stored distance width
    localparam int unsigned DIFF_W  = 33;  // bound minus origin, signed
    localparam int unsigned QW      = 31;  // unsaturated quotient bits
    localparam int unsigned CNT_W   = 5;   // divider step counter
    localparam int unsigned IDX_W   = 8;   // register index width on the config port

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_ORG_X = 8'd0;
    localparam logic [IDX_W-1:0] REG_ORG_Y = 8'd1;
    localparam logic [IDX_W-1:0] REG_ORG_Z = 8'd2;
    localparam logic [IDX_W-1:0] REG_DIR_X = 8'd3;
    localparam logic [IDX_W-1:0] REG_DIR_Y = 8'd4;
    localparam logic [IDX_W-1:0] REG_DIR_Z = 8'd5;

    // Reset value of the z direction: 1.0 in Q2.30.
    localparam logic [CW-1:0] DIR_Z_RESET = 32'h4000_0000;

    // Largest distance, Q16.16.
    localparam logic signed [CW-1:0] DIST_MAX = 32'sh7FFF_FFFF;

    // Ray as held in the configuration registers, axis 0 is x.
    typedef struct packed {
        logic [2:0][CW-1:0] org;
        logic [2:0][CW-1:0] dir;
    } t_ray;

    // One classified box waiting for the back end.
    typedef struct packed {
        logic [2:0][DIFF_W-1:0] d_lo;   // box_min - origin per axis
        logic [2:0][DIFF_W-1:0] d_hi;   // box_max - origin per axis
        logic [CW-1:0]          owner;
        logic                   last;
    } t_job;

    // Divider request and response.
    typedef struct packed {
        logic              start;
        logic [DIFF_W-1:0] diff;
        logic [CW-1:0]     dir;
    } t_div_req;

    typedef struct packed {
        logic          done;
        logic [CW-1:0] t;
    } t_div_rsp;

endpackage

### rtl/rbch_div.sv
// ----------------------------------------------------------------------------
// rbch_div: slab distance divider
// Computes diff * 2^30 / dir, truncated toward zero and saturated to
// +/-(2^31-1), one quotient bit per cycle (restoring division).
// ----------------------------------------------------------------------------
module rbch_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rbch_pkg::t_div_req  i_req,
    output rbch_pkg::t_div_rsp  o_rsp
);

    logic [rbch_pkg::DIFF_W-1:0] abs_diff;
    logic [rbch_pkg::CW-1:0]     abs_dir;
    logic                        sat;
    logic [rbch_pkg::CW:0]       rem2;
    logic                        ge;
    logic [rbch_pkg::CW:0]       rem_sub;

    logic                        r_busy;
    logic                        r_done;
    logic                        r_neg;
    logic                        r_b0;
    logic [rbch_pkg::CNT_W-1:0]  r_cnt;
    logic [rbch_pkg::CW-1:0]     r_den;
    logic [rbch_pkg::CW-1:0]     r_rem;
    logic [rbch_pkg::QW-1:0]     r_quot;

    // Magnitudes and the saturation test: the quotient reaches 2^31
    // exactly when |diff| >= 2 * |dir|.
    always_comb begin
        abs_diff = i_req.diff[rbch_pkg::DIFF_W-1] ? (~i_req.diff + 1'b1) : i_req.diff;
        abs_dir  = i_req.dir[rbch_pkg::CW-1] ? (~i_req.dir + 1'b1) : i_req.dir;
        sat      = {1'b0, abs_diff} >= {1'b0, abs_dir, 1'b0};
    end

    // One restoring step.
    always_comb begin
        rem2    = {r_rem, r_b0};
        ge      = rem2 >= {1'b0, r_den};
        rem_sub = rem2 - {1'b0, r_den};
    end

    // Step sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_neg <= i_req.diff[rbch_pkg::DIFF_W-1] ^ i_req.dir[rbch_pkg::CW-1];
                r_den <= abs_dir;
                if (sat) begin
                    r_quot <= '1;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    // Leading 32 quotient bits are zero: start with the
                    // partial remainder that they leave.
                    r_rem  <= abs_diff[rbch_pkg::DIFF_W-1:1];
                    r_b0   <= abs_diff[0];
                    r_quot <= '0;
                    r_cnt  <= rbch_pkg::CNT_W'(rbch_pkg::QW);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem  <= ge ? rem_sub[rbch_pkg::CW-1:0] : rem2[rbch_pkg::CW-1:0];
                r_b0   <= 1'b0;
                r_quot <= {r_quot[rbch_pkg::QW-2:0], ge};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == rbch_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Signed result.
    always_comb begin
        o_rsp.done = r_done;
        o_rsp.t    = r_neg ? (~{1'b0, r_quot} + 1'b1) : {1'b0, r_quot};
    end

endmodule

### rtl/rbch_front.sv
// ----------------------------------------------------------------------------
// rbch_front: box intake
// Accepts boxes, forms bound-minus-origin differences on all axes and
// holds the words in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rbch_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rbch_pkg::t_ray       i_ray,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0][31:0]     i_lo,
    input  logic [2:0][31:0]     i_hi,
    input  logic [31:0]          i_owner,
    input  logic                 i_last,
    output logic                 o_job_valid,
    output rbch_pkg::t_job       o_job,
    input  logic                 i_pop
);

    rbch_pkg::t_job r_mem [2];
    rbch_pkg::t_job n_job;
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    logic           pop;

    // Differences to the ray origin, sign-extended to 33 bits.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_job.d_lo[a] = {i_lo[a][31], i_lo[a]} - {i_ray.org[a][31], i_ray.org[a]};
            n_job.d_hi[a] = {i_hi[a][31], i_hi[a]} - {i_ray.org[a][31], i_ray.org[a]};
        end
        n_job.owner = i_owner;
        n_job.last  = i_last;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready;
    assign pop         = i_pop && (r_cnt != 2'd0);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_mem[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= n_job;
        end
    end

    // Queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/rbch_back.sv
// ----------------------------------------------------------------------------
// rbch_back: slab test and nearest-hit tracking
// Walks the six slab bounds of one box, dividing each non-parallel one in
// the shared divider, narrows the entry/exit interval, keeps the nearest hit
// and registers the result word at the end of a query.
// ----------------------------------------------------------------------------
module rbch_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rbch_pkg::t_ray       i_ray,
    input  logic                 i_job_valid,
    input  rbch_pkg::t_job       i_job,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_found,
    output logic [31:0]          o_owner,
    output logic [30:0]          o_dist
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOAD   = 4'b0010,
        S_DIV    = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state                    r_state;
    rbch_pkg::t_job            r_job;
    logic [2:0]                r_k;
    logic signed [31:0]        r_t1;
    logic signed [31:0]        r_tmin;
    logic signed [31:0]        r_tmax;
    logic                      r_miss;
    logic                      r_any;
    logic [30:0]               r_near_d;
    logic [31:0]               r_near_o;
    logic                      r_ov;
    logic                      r_of;
    logic [31:0]               r_oo;
    logic [30:0]               r_od;

    logic [1:0]                axis;
    logic                      side;
    logic [31:0]               dir_sel;
    logic [32:0]               diff_sel;
    rbch_pkg::t_div_req        div_req;
    rbch_pkg::t_div_rsp        div_rsp;
    logic signed [31:0]        t_new;
    logic signed [31:0]        t_lo;
    logic signed [31:0]        t_hi;
    logic                      hit;
    logic                      take;
    logic                      out_free;
    logic                      emit;
    logic [30:0]               fin_d;
    logic [31:0]               fin_o;
    logic                      fin_any;

    // Current slab: axis from the step number, lower bound on even steps.
    always_comb begin
        axis     = r_k[2:1];
        side     = r_k[0];
        dir_sel  = i_ray.dir[axis];
        diff_sel = side ? r_job.d_hi[axis] : r_job.d_lo[axis];
    end

    rbch_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        div_req.start = (r_state == S_LOAD) && (dir_sel != '0);
        div_req.diff  = diff_sel;
        div_req.dir   = dir_sel;
    end

    // Order the slab pair.
    always_comb begin
        t_new = signed'(div_rsp.t);
        t_lo  = (r_t1 > t_new) ? t_new : r_t1;
        t_hi  = (r_t1 > t_new) ? r_t1 : t_new;
    end

    // Nearest-hit update for the finished box.
    always_comb begin
        hit      = !r_miss && !(r_tmin > r_tmax);
        take     = hit && (!r_any || (r_tmin[30:0] < r_near_d));
        fin_d    = take ? r_tmin[30:0] : r_near_d;
        fin_o    = take ? r_job.owner : r_near_o;
        fin_any  = r_any || take;
        out_free = !r_ov || i_ready;
        emit     = (r_state == S_FINISH) && r_job.last && out_free;
    end

    assign o_pop   = (r_state == S_IDLE) && i_job_valid;
    assign o_valid = r_ov;
    assign o_found = r_of;
    assign o_owner = r_oo;
    assign o_dist  = r_od;

    // Payload of the current box.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == S_DIV && div_rsp.done && !side) begin
            r_t1 <= t_new;
        end
    end

    // Sequencer, interval and nearest-hit state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= '0;
            r_tmin   <= '0;
            r_tmax   <= rbch_pkg::DIST_MAX;
            r_miss   <= 1'b0;
            r_any    <= 1'b0;
            r_near_d <= '1;
            r_near_o <= '0;
            r_ov     <= 1'b0;
        end else begin
            // Result valid: set when a query ends, cleared when taken.
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_k     <= '0;
                        r_tmin  <= '0;
                        r_tmax  <= rbch_pkg::DIST_MAX;
                        r_miss  <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (dir_sel == '0) begin
                        // Parallel slab: origin must lie between the bounds.
                        if (!side && !diff_sel[32] && diff_sel != '0) begin
                            r_miss <= 1'b1;
                        end
                        if (side && diff_sel[32]) begin
                            r_miss <= 1'b1;
                        end
                        if (r_k == 3'd5) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_k <= r_k + 3'd1;
                        end
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        if (side) begin
                            if (t_lo > r_tmin) begin
                                r_tmin <= t_lo;
                            end
                            if (t_hi < r_tmax) begin
                                r_tmax <= t_hi;
                            end
                        end
                        if (r_k == 3'd5) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_k     <= r_k + 3'd1;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_FINISH: begin
                    if (!r_job.last) begin
                        r_near_d <= fin_d;
                        r_near_o <= fin_o;
                        r_any    <= fin_any;
                        r_state  <= S_IDLE;
                    end else if (out_free) begin
                        r_near_d <= '1;
                        r_near_o <= '0;
                        r_any    <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result word.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_of <= fin_any;
            r_oo <= fin_any ? fin_o : '0;
            r_od <= fin_any ? fin_d : '0;
        end
    end

endmodule

### rtl/ray_box_closest_hit.sv
// ----------------------------------------------------------------------------
// ray_box_closest_hit: nearest ray/box hit over a stream of boxes
//
//  Channel  Dir  Handshake                   Words
//  s_axis   in   s_axis_tvalid/tready        one box, tlast ends the query
//  m_axis   out  m_axis_tvalid/tready        one result per query
//  cfg      in   i_cfg_valid/o_cfg_ready     register index and data
//
// Each non-parallel slab bound is loaded, then divided in the shared
// bit-serial divider, which skips the bit steps when the distance
// saturates; six bounds per box.
// A two-word queue lets boxes be taken while the back end works.
// Reset is synchronous, active low; the ray returns to origin 0, dir +z.
// The result register holds its word until taken; the back end waits on
// it only at the end of a query.
// ----------------------------------------------------------------------------
module ray_box_closest_hit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    // box_owner (32 bits each, lowest first)
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [223:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    // hit_owner [31:0], hit_distance [62:32], zero [63]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,
    // hit_found [0]
    output logic         m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    rbch_pkg::t_ray  r_ray;
    rbch_pkg::t_job  job;
    logic            job_valid;
    logic            pop;
    logic [2:0][31:0] box_lo;
    logic [2:0][31:0] box_hi;
    logic            found;
    logic [31:0]     owner;
    logic [30:0]     hit_dist;

    assign o_cfg_ready = 1'b1;

    // Ray registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ray.org    <= '0;
            r_ray.dir[0] <= '0;
            r_ray.dir[1] <= '0;
            r_ray.dir[2] <= rbch_pkg::DIR_Z_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rbch_pkg::REG_ORG_X: r_ray.org[0] <= i_cfg_data;
                rbch_pkg::REG_ORG_Y: r_ray.org[1] <= i_cfg_data;
                rbch_pkg::REG_ORG_Z: r_ray.org[2] <= i_cfg_data;
                rbch_pkg::REG_DIR_X: r_ray.dir[0] <= i_cfg_data;
                rbch_pkg::REG_DIR_Y: r_ray.dir[1] <= i_cfg_data;
                rbch_pkg::REG_DIR_Z: r_ray.dir[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack box bounds.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            box_lo[a] = s_axis_tdata[32*a +: 32];
            box_hi[a] = s_axis_tdata[32*(a+3) +: 32];
        end
    end

    rbch_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ray       (r_ray),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_lo        (box_lo),
        .i_hi        (box_hi),
        .i_owner     (s_axis_tdata[223:192]),
        .i_last      (s_axis_tlast),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_pop       (pop)
    );

    rbch_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ray       (r_ray),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_found     (found),
        .o_owner     (owner),
        .o_dist      (hit_dist)
    );

    assign m_axis_tdata = {1'b0, hit_dist, owner};
    assign m_axis_tuser = found;

endmodule

### dv/ray_box_closest_hit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_box_closest_hit_tb: self-checking bench for the ray/box closest-hit block
// Streams boxes under several ray settings, predicts the nearest hit of each
// query with a slab-method model and compares every result word field by
// field. Both stream sides idle at random, with one stretch at full rate.
// ----------------------------------------------------------------------------
module ray_box_closest_hit_tb;

    localparam int unsigned LIMIT_CYCLES = 2_000_000;

    typedef struct packed {
        logic          found;
        logic [31:0]   owner;
        logic [30:0]   hit_dist;
    } t_hit;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [223:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [7:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    // Predictor copy of the ray and of the running nearest hit.
    logic signed [31:0] ray_org [3];
    logic signed [31:0] ray_dir [3];
    logic [30:0]        near_dist;
    logic [31:0]        near_owner;
    logic               near_any;

    t_hit        hit_queue[$];
    int unsigned fail_count;
    int unsigned cycle_count;
    bit          idle_enable;

    ray_box_closest_hit dut (.*);

    // Clock.
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Slab distance: diff * 2^30 / dir, truncated toward zero, saturated.
    function automatic longint slab_distance(longint diff, longint dir);
        logic [127:0] num;
        logic [127:0] quo;
        longint       den;
        bit           neg;
        neg = (diff < 0) != (dir < 0);
        num = 128'(diff < 0 ? -diff : diff) << 30;
        den = dir < 0 ? -dir : dir;
        quo = num / 128'(den);
        if (quo > 128'h7FFF_FFFF) quo = 128'h7FFF_FFFF;
        return neg ? -longint'(quo) : longint'(quo);
    endfunction

    // Fold one box into the nearest-hit search; queue a result on the last box.
    task automatic predict_box(logic [223:0] box, logic last);
        longint tmin;
        longint tmax;
        longint lo;
        longint hi;
        longint org;
        longint t1;
        longint t2;
        longint sw;
        bit     hit;
        t_hit   res;
        tmin = 0;
        tmax = 64'h7FFF_FFFF;
        hit  = 1'b1;
        for (int a = 0; a < 3 && hit; a++) begin
            lo  = longint'(signed'(box[32*a +: 32]));
            hi  = longint'(signed'(box[32*(a+3) +: 32]));
            org = longint'(ray_org[a]);
            if (ray_dir[a] == 0) begin
                if (org < lo || org > hi) hit = 1'b0;
            end else begin
                t1 = slab_distance(lo - org, longint'(ray_dir[a]));
                t2 = slab_distance(hi - org, longint'(ray_dir[a]));
                if (t1 > t2) begin
                    sw = t1; t1 = t2; t2 = sw;
                end
                if (t1 > tmin) tmin = t1;
                if (t2 < tmax) tmax = t2;
                if (tmin > tmax) hit = 1'b0;
            end
        end
        if (hit && (!near_any || tmin < longint'(near_dist))) begin
            near_dist  = tmin[30:0];
            near_owner = box[192 +: 32];
            near_any   = 1'b1;
        end
        if (last) begin
            res.found    = near_any;
            res.owner    = near_any ? near_owner : 32'd0;
            res.hit_dist = near_any ? near_dist : 31'd0;
            hit_queue    = {hit_queue, res};
            near_dist  = '1;
            near_owner = '0;
            near_any   = 1'b0;
        end
    endtask

    // Send one box word and wait for it to be taken. Valid stays high after
    // the word is taken so that words can follow back to back.
    task automatic send_box(logic [223:0] box, logic last);
        if (idle_enable && $urandom_range(99) < 37) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while (idle_enable && $urandom_range(99) < 37) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= box;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_box(box, last);
    endtask

    // Stop the stream, wait until every expected result has come, then let
    // the block settle.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (hit_queue.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    // Register write; only called while the block is idle.
    task automatic write_reg(logic [7:0] idx, logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx <= rbch_pkg::REG_DIR_Z) begin
            if (idx < rbch_pkg::REG_DIR_X) ray_org[idx[1:0]] = value;
            else ray_dir[2'(idx - rbch_pkg::REG_DIR_X)] = value;
        end
    endtask

    task automatic set_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
        write_reg(rbch_pkg::REG_ORG_X, ox);
        write_reg(rbch_pkg::REG_ORG_Y, oy);
        write_reg(rbch_pkg::REG_ORG_Z, oz);
        write_reg(rbch_pkg::REG_DIR_X, dx);
        write_reg(rbch_pkg::REG_DIR_Y, dy);
        write_reg(rbch_pkg::REG_DIR_Z, dz);
    endtask

    function automatic logic [223:0] make_box(logic [31:0] lx, logic [31:0] ly,
                                              logic [31:0] lz, logic [31:0] hx,
                                              logic [31:0] hy, logic [31:0] hz,
                                              logic [31:0] owner);
        return {owner, hz, hy, hx, lz, ly, lx};
    endfunction

    // Random coordinate: mostly near the ray, sometimes anywhere.
    function automatic logic [31:0] rand_coord();
        if ($urandom_range(9) == 0) return $urandom();
        return 32'(signed'($urandom_range(0, 40 << 16)) - (20 << 16));
    endfunction

    function automatic logic [31:0] rand_dir();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return $urandom_range(1) ? 32'h4000_0000 : 32'hC000_0000;
            2: return $urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF;
            3: return $urandom();
            default: return 32'(signed'($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
        endcase
    endfunction

    // Box that mostly brackets a range; sometimes inverted or arbitrary.
    function automatic logic [223:0] rand_box();
        logic [31:0] lo [3];
        logic [31:0] hi [3];
        logic [31:0] c;
        for (int a = 0; a < 3; a++) begin
            c = rand_coord();
            lo[a] = c;
            hi[a] = c + $urandom_range(0, 8 << 16);
            if ($urandom_range(19) == 0) begin
                lo[a] = hi[a]; hi[a] = c;
            end
            if ($urandom_range(29) == 0) begin
                lo[a] = $urandom(); hi[a] = $urandom();
            end
        end
        return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], $urandom());
    endfunction

    // Result checker and receiver stalls.
    always @(posedge i_clk) begin
        t_hit want;
        if (i_rst_n) begin
            m_axis_tready <= !idle_enable || ($urandom_range(99) >= 37);
            if (m_axis_tvalid && m_axis_tready) begin
                if (hit_queue.size() == 0) begin
                    $error("unexpected result word");
                    fail_count++;
                end else begin
                    want = hit_queue.pop_front();
                    if (m_axis_tuser !== want.found) begin
                        $error("hit_found: expected %0d, got %0d", want.found, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tdata[31:0] !== want.owner) begin
                        $error("hit_owner: expected %h, got %h",
                               want.owner, m_axis_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[62:32] !== want.hit_dist) begin
                        $error("hit_distance: expected %h, got %h",
                               want.hit_dist, m_axis_tdata[62:32]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("ray_box_closest_hit test failed");
            $finish;
        end
    end

    // Default ray straight up z: boxes hit, missed, tie, far, no hit.
    task automatic test_default_ray();
        send_box(make_box(32'hFFFF_0000, 32'hFFFF_0000, 32'h0005_0000,
                          32'h0001_0000, 32'h0001_0000, 32'h0006_0000, 32'd11), 1'b0);
        send_box(make_box(32'hFFFF_0000, 32'hFFFF_0000, 32'h0005_0000,
                          32'h0001_0000, 32'h0001_0000, 32'h0009_0000, 32'd22), 1'b0);
        send_box(make_box(32'hFFFF_0000, 32'hFFFF_0000, 32'h0002_0000,
                          32'h0001_0000, 32'h0001_0000, 32'h0003_0000, 32'd33), 1'b1);
        // Parallel axis missed: origin outside x slab.
        send_box(make_box(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000,
                          32'h0002_0000, 32'h0001_0000, 32'h0003_0000, 32'd44), 1'b1);
        // Inverted box on a parallel axis always misses.
        send_box(make_box(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000,
                          32'hFFFF_0000, 32'h0001_0000, 32'h0003_0000, 32'd45), 1'b1);
        // Extremes of every field; origin inside a full box.
        send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF), 1'b1);
        send_box(make_box(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0), 1'b1);
        // Far box near the largest distance, then tie with a later one.
        send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h7FFF_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd5), 1'b0);
        send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h7FFF_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd6), 1'b1);
        wait_drained();
    endtask

    // Tiny and extreme directions saturate the slab distances.
    task automatic test_extreme_rays();
        set_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'h4000_0000);
        send_box(make_box(32'h0000_0000, 32'h0000_0000, 32'h0001_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0002_0000, 32'd7), 1'b1);
        send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd8), 1'b1);
        wait_drained();
        set_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h7FFF_FFFF, 32'hC000_0000);
        send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd9), 1'b1);
        send_box(make_box(32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                          32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'd10), 1'b1);
        wait_drained();
        // Write to an unused index is ignored.
        write_reg(8'hFF, $urandom());
    endtask

    // Random queries under a random ray, without idling when full_rate is set.
    task automatic test_random_queries(int unsigned n_boxes, bit full_rate);
        int unsigned sent;
        int unsigned qlen;
        idle_enable = !full_rate;
        set_ray(rand_coord(), rand_coord(), rand_coord(), rand_dir(), rand_dir(), rand_dir());
        sent = 0;
        while (sent < n_boxes) begin
            qlen = $urandom_range(1, 8);
            for (int k = 1; k <= qlen; k++) begin
                send_box(rand_box(), k == qlen);
                sent++;
            end
        end
        wait_drained();
        idle_enable = 1'b1;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        fail_count  = 0;
        cycle_count = 0;
        idle_enable = 1'b1;
        ray_org = '{32'sd0, 32'sd0, 32'sd0};
        ray_dir = '{32'sd0, 32'sd0, signed'(rbch_pkg::DIR_Z_RESET)};
        near_dist  = '1;
        near_owner = '0;
        near_any   = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_ray();
        test_extreme_rays();
        for (int p = 0; p < 14; p++) test_random_queries(100, p == 3);

        if (fail_count == 0) begin
            $display("ray_box_closest_hit test passed");
        end else begin
            $display("ray_box_closest_hit test failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/rbch_pkg.sv
rtl/rbch_div.sv
rtl/rbch_front.sv
rtl/rbch_back.sv
rtl/ray_box_closest_hit.sv
dv/ray_box_closest_hit_tb.sv
